// File: src/gocn_pkg.sv
package gocn_pkg;

  localparam int CELL_W     = 8;
  localparam int POS_W      = 16;
  localparam int COORD_W    = 14;
  localparam int DIST_W     = 32;
  localparam int COUNT_W    = 11;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [CELL_W-1:0] OCCUPIED = 8'sd100;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LINK_RADIUS = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NEAR_THRESH = 2'd3;

  localparam logic [COORD_W-1:0] COORD_MAX = 14'd16383;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

endpackage

// File: src/gocn_ifs.sv
interface gocn_in_if;
  import gocn_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;
  logic                     last_cell;
  logic signed [POS_W-1:0]  robot_x;
  logic signed [POS_W-1:0]  robot_y;
  modport source (output valid, cell_value, last_cell, robot_x, robot_y, input ready);
  modport sink   (input valid, cell_value, last_cell, robot_x, robot_y, output ready);
endinterface

interface gocn_out_if;
  import gocn_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [COUNT_W-1:0] cluster_count;
  logic [COORD_W-1:0] centroid_x;
  logic [COORD_W-1:0] centroid_y;
  logic [DIST_W-1:0]  distance_sq;
  logic               far_enough;
  logic               point_overflow;
  modport source (output valid, found, cluster_count, centroid_x, centroid_y, distance_sq,
                  far_enough, point_overflow, input ready);
  modport sink   (input valid, found, cluster_count, centroid_x, centroid_y, distance_sq,
                  far_enough, point_overflow, output ready);
endinterface

interface gocn_cfg_if;
  import gocn_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: src/gocn_ram.sv
module gocn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/grid_obstacle_cluster_nearest.sv
// Nearest obstacle cluster on an occupancy grid.
//
// Cells arrive on in_ch in row-major order, one transaction per cycle, while the
// block is streaming. A cell of value 100 is kept as a point in the point store.
// The transaction that carries last_cell also supplies the robot position; after
// it in_ch.ready falls while the points are clustered. For each seed the block
// walks the later points once, reading and checking each candidate; each is tested
// against the members so far by reading the member index, then the member point,
// then comparing. Each seed is read and checked. A cluster then needs two serial
// divisions (a load and 28 quotient bits each), two squarings and a compare for
// the distance. One result transaction appears on out_ch after clustering; cells
// that are not the last give no result. The result waits in an output register;
// the block resumes streaming once it is loaded, so a stalled receiver only holds
// the block at the end of the next frame. cfg_ch is always ready and should be
// written only while the block is idle. Reset sets the registers to their
// defaults and empties the point store; no clearing pass is needed because the
// done marks are written as each point is stored.
module grid_obstacle_cluster_nearest #(
  parameter int GRID_MAX_SIDE = 64,
  parameter int MAX_POINTS    = 1024,
  parameter int FRAC_BITS     = 8
) (
  input logic clk,
  input logic rst_n,
  gocn_in_if.sink    in_ch,
  gocn_out_if.source out_ch,
  gocn_cfg_if.sink   cfg_ch
);
  import gocn_pkg::*;

  localparam int CW    = $clog2(GRID_MAX_SIDE);
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int SW    = CW + NW;
  localparam int NUMW  = SW + 3 + FRAC_BITS;
  localparam int DCW   = $clog2(NUMW + 1);
  localparam int SIDEW = $clog2(GRID_MAX_SIDE + 1);
  localparam int LW    = (2 * CW + 3 > 14) ? 2 * CW + 3 : 14;

  typedef enum logic [13:0] {
    S_STREAM   = 14'b00000000000001,
    S_SEED_RD  = 14'b00000000000010,
    S_SEED_CHK = 14'b00000000000100,
    S_J_RD     = 14'b00000000001000,
    S_J_CHK    = 14'b00000000010000,
    S_K_RD     = 14'b00000000100000,
    S_K_PT     = 14'b00000001000000,
    S_K_CMP    = 14'b00000010000000,
    S_DIV_LD   = 14'b00000100000000,
    S_DIV      = 14'b00001000000000,
    S_SQX      = 14'b00010000000000,
    S_SQY      = 14'b00100000000000,
    S_BEST     = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [6:0]  grid_w_r, grid_h_r;
  logic [13:0] link_r;
  logic [31:0] thresh_r;

  // Frame collection.
  logic [NW-1:0] pcount_r;
  logic [CW-1:0] col_r, row_r;
  logic          ovf_r;
  logic signed [POS_W-1:0] rx_r, ry_r;

  // Clustering.
  logic [NW-1:0] i_r, j_r, k_r, members_r;
  logic [CW-1:0] pj_col_r, pj_row_r;
  logic [SW-1:0] sx_r, sy_r;
  logic [NUMW-1:0] num_r;
  logic [NW:0]     den_r;
  logic [NW+1:0]   rem_r;
  logic [DCW-1:0]  dstep_r;
  logic            div_y_r;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic [33:0]        sqx_r, sqy_r;
  logic               found_r;
  logic [COUNT_W-1:0] clusters_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [COORD_W-1:0] best_cx_r, best_cy_r;

  // Output register.
  logic               ov_r;
  logic               o_found_r, o_far_r, o_ovf_r;
  logic [COUNT_W-1:0] o_count_r;
  logic [COORD_W-1:0] o_cx_r, o_cy_r;
  logic [DIST_W-1:0]  o_d_r;

  // Memories.
  logic          pt_we, done_we, mem_we, done_wdata;
  logic [AW-1:0] pt_waddr, done_waddr, mem_waddr, pt_raddr, mem_raddr;
  logic [2*CW-1:0] pt_wdata, pt_rdata;
  logic            done_rdata;
  logic [AW-1:0]   mem_wdata, mem_rdata;

  gocn_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_points (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );
  gocn_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_done (
    .clk, .we(done_we), .waddr(done_waddr), .wdata(done_wdata),
    .raddr(pt_raddr), .rdata(done_rdata)
  );
  gocn_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_members (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic in_acc;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_STREAM);
  assign cfg_ch.ready = 1'b1;

  // A width or height of zero acts as one, and one above the maximum side is clamped.
  logic [SIDEW-1:0] w_eff, h_eff;
  always_comb begin
    if (grid_w_r == 7'd0) w_eff = SIDEW'(1);
    else if (32'(grid_w_r) > 32'(GRID_MAX_SIDE)) w_eff = SIDEW'(GRID_MAX_SIDE);
    else w_eff = SIDEW'(grid_w_r);
    if (grid_h_r == 7'd0) h_eff = SIDEW'(1);
    else if (32'(grid_h_r) > 32'(GRID_MAX_SIDE)) h_eff = SIDEW'(GRID_MAX_SIDE);
    else h_eff = SIDEW'(grid_h_r);
  end

  logic occupied, store_pt;
  assign occupied = (in_ch.cell_value == OCCUPIED);
  assign store_pt = in_acc && occupied && (32'(pcount_r) < 32'(MAX_POINTS));

  // Link test between the candidate and the member point just read.
  logic [CW-1:0]        m_col, m_row;
  logic signed [CW:0]   dc, dr;
  logic [2*CW+1:0]      dc2, dr2;
  logic [LW-1:0]        link_d;
  logic                 linked;
  always_comb begin
    m_col  = pt_rdata[2*CW-1:CW];
    m_row  = pt_rdata[CW-1:0];
    dc     = $signed({1'b0, pj_col_r}) - $signed({1'b0, m_col});
    dr     = $signed({1'b0, pj_row_r}) - $signed({1'b0, m_row});
    dc2    = (2*CW+2)'(dc * dc);
    dr2    = (2*CW+2)'(dr * dr);
    link_d = LW'(dc2) + LW'(dr2);
    linked = (link_d <= LW'(link_r));
  end

  // Restoring division, one quotient bit a cycle.
  logic [NW+1:0]      trial;
  logic               qbit;
  logic [NUMW-1:0]    q_next;
  logic [NUMW+13:0]   q_ext;
  logic [COORD_W-1:0] q_sat;
  always_comb begin
    trial  = {rem_r[NW:0], num_r[NUMW-1]};
    qbit   = (trial >= {1'b0, den_r});
    q_next = {num_r[NUMW-2:0], qbit};
    q_ext  = (NUMW+14)'(q_next);
    q_sat  = (q_ext > (NUMW+14)'(COORD_MAX)) ? COORD_MAX : q_ext[COORD_W-1:0];
  end

  logic [SW-1:0] div_sum;
  assign div_sum = div_y_r ? sy_r : sx_r;

  // Shared squarer for the distance terms.
  logic signed [16:0] mul_a;
  logic [33:0]        sq;
  logic [34:0]        d_sum;
  logic [DIST_W-1:0]  d_sat;
  always_comb begin
    if (state_r == S_SQX) mul_a = $signed({3'b000, cx_r}) - $signed({rx_r[15], rx_r});
    else                  mul_a = $signed({3'b000, cy_r}) - $signed({ry_r[15], ry_r});
    sq    = 34'(mul_a * mul_a);
    d_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
    d_sat = (d_sum[34:32] != 3'b000) ? {DIST_W{1'b1}} : d_sum[31:0];
  end

  // Memory ports.
  always_comb begin
    pt_we      = store_pt;
    pt_waddr   = pcount_r[AW-1:0];
    pt_wdata   = {col_r, row_r};
    done_we    = store_pt;
    done_waddr = pcount_r[AW-1:0];
    done_wdata = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = members_r[AW-1:0];
    mem_wdata  = j_r[AW-1:0];
    mem_raddr  = k_r[AW-1:0];
    unique case (state_r)
      S_SEED_RD: pt_raddr = i_r[AW-1:0];
      S_K_PT:    pt_raddr = mem_rdata;
      default:   pt_raddr = j_r[AW-1:0];
    endcase
    if (state_r == S_SEED_CHK && !done_rdata) begin
      done_we    = 1'b1;
      done_waddr = i_r[AW-1:0];
      done_wdata = 1'b1;
      mem_we     = 1'b1;
      mem_waddr  = '0;
      mem_wdata  = i_r[AW-1:0];
    end else if (state_r == S_K_CMP && linked) begin
      done_we    = 1'b1;
      done_waddr = j_r[AW-1:0];
      done_wdata = 1'b1;
      mem_we     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_STREAM;
      grid_w_r   <= 7'd64;
      grid_h_r   <= 7'd64;
      link_r     <= 14'd1;
      thresh_r   <= 32'd65536;
      pcount_r   <= '0;
      col_r      <= '0;
      row_r      <= '0;
      ovf_r      <= 1'b0;
      ov_r       <= 1'b0;
      found_r    <= 1'b0;
      clusters_r <= '0;
      best_d_r   <= '0;
      best_cx_r  <= '0;
      best_cy_r  <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.addr)
          REG_GRID_WIDTH:  grid_w_r <= cfg_ch.data[6:0];
          REG_GRID_HEIGHT: grid_h_r <= cfg_ch.data[6:0];
          REG_LINK_RADIUS: link_r   <= cfg_ch.data[13:0];
          REG_NEAR_THRESH: thresh_r <= cfg_ch.data;
        endcase
      end
      // In the final state the output register is reloaded below instead.
      if (ov_r && out_ch.ready && state_r != S_FIN) begin
        ov_r <= 1'b0;
      end

      unique case (state_r)
        S_STREAM: begin
          if (in_acc) begin
            if (store_pt) pcount_r <= pcount_r + NW'(1);
            else if (occupied) ovf_r <= 1'b1;
            if (32'(col_r) + 32'd1 >= 32'(w_eff)) begin
              col_r <= '0;
              row_r <= (32'(row_r) + 32'd1 >= 32'(h_eff)) ? '0 : row_r + CW'(1);
            end else begin
              col_r <= col_r + CW'(1);
            end
            if (in_ch.last_cell) begin
              rx_r       <= in_ch.robot_x;
              ry_r       <= in_ch.robot_y;
              i_r        <= '0;
              found_r    <= 1'b0;
              clusters_r <= '0;
              best_d_r   <= '0;
              best_cx_r  <= '0;
              best_cy_r  <= '0;
              state_r    <= S_SEED_RD;
            end
          end
        end
        S_SEED_RD: begin
          state_r <= (i_r >= pcount_r) ? S_FIN : S_SEED_CHK;
        end
        S_SEED_CHK: begin
          if (done_rdata) begin
            i_r     <= i_r + NW'(1);
            state_r <= S_SEED_RD;
          end else begin
            members_r <= NW'(1);
            sx_r      <= SW'(pt_rdata[2*CW-1:CW]);
            sy_r      <= SW'(pt_rdata[CW-1:0]);
            j_r       <= i_r + NW'(1);
            state_r   <= S_J_RD;
          end
        end
        S_J_RD: begin
          state_r <= (j_r >= pcount_r) ? S_DIV_LD : S_J_CHK;
          div_y_r <= 1'b0;
        end
        S_J_CHK: begin
          if (done_rdata) begin
            j_r     <= j_r + NW'(1);
            state_r <= S_J_RD;
          end else begin
            pj_col_r <= pt_rdata[2*CW-1:CW];
            pj_row_r <= pt_rdata[CW-1:0];
            k_r      <= '0;
            state_r  <= S_K_RD;
          end
        end
        S_K_RD: state_r <= S_K_PT;
        S_K_PT: state_r <= S_K_CMP;
        S_K_CMP: begin
          if (linked) begin
            members_r <= members_r + NW'(1);
            sx_r      <= sx_r + SW'(pj_col_r);
            sy_r      <= sy_r + SW'(pj_row_r);
            j_r       <= j_r + NW'(1);
            state_r   <= S_J_RD;
          end else if (k_r + NW'(1) >= members_r) begin
            j_r     <= j_r + NW'(1);
            state_r <= S_J_RD;
          end else begin
            k_r     <= k_r + NW'(1);
            state_r <= S_K_RD;
          end
        end
        S_DIV_LD: begin
          // Numerator ((2*sum + n) << FRAC_BITS) + n over 2n rounds to nearest.
          num_r   <= ((NUMW'(div_sum) * NUMW'(2) + NUMW'(members_r)) << FRAC_BITS)
                     + NUMW'(members_r);
          den_r   <= {members_r, 1'b0};
          rem_r   <= '0;
          dstep_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          num_r   <= q_next;
          rem_r   <= qbit ? (trial - {1'b0, den_r}) : trial;
          dstep_r <= dstep_r + DCW'(1);
          if (32'(dstep_r) == NUMW - 1) begin
            if (div_y_r) begin
              cy_r    <= q_sat;
              state_r <= S_SQX;
            end else begin
              cx_r    <= q_sat;
              div_y_r <= 1'b1;
              state_r <= S_DIV_LD;
            end
          end
        end
        S_SQX: begin
          sqx_r   <= sq;
          state_r <= S_SQY;
        end
        S_SQY: begin
          sqy_r   <= sq;
          state_r <= S_BEST;
        end
        S_BEST: begin
          if (!found_r || d_sat < best_d_r) begin
            best_d_r  <= d_sat;
            best_cx_r <= cx_r;
            best_cy_r <= cy_r;
          end
          found_r <= 1'b1;
          if (clusters_r != COUNT_MAX) clusters_r <= clusters_r + COUNT_W'(1);
          i_r     <= i_r + NW'(1);
          state_r <= S_SEED_RD;
        end
        S_FIN: begin
          if (!ov_r || out_ch.ready) begin
            ov_r      <= 1'b1;
            o_found_r <= found_r;
            o_count_r <= clusters_r;
            o_cx_r    <= best_cx_r;
            o_cy_r    <= best_cy_r;
            o_d_r     <= best_d_r;
            o_far_r   <= found_r && (best_d_r >= thresh_r);
            o_ovf_r   <= ovf_r;
            pcount_r  <= '0;
            col_r     <= '0;
            row_r     <= '0;
            ovf_r     <= 1'b0;
            state_r   <= S_STREAM;
          end
        end
        default: state_r <= S_STREAM;
      endcase
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.found          = o_found_r;
  assign out_ch.cluster_count  = o_count_r;
  assign out_ch.centroid_x     = o_cx_r;
  assign out_ch.centroid_y     = o_cy_r;
  assign out_ch.distance_sq    = o_d_r;
  assign out_ch.far_enough     = o_far_r;
  assign out_ch.point_overflow = o_ovf_r;

endmodule

// File: tb/gocn_scoreboard.sv
class gocn_scoreboard;
  typedef struct packed {
    logic        found;
    logic [10:0] cluster_count;
    logic [13:0] centroid_x;
    logic [13:0] centroid_y;
    logic [31:0] distance_sq;
    logic        far_enough;
    logic        point_overflow;
  } frame_result_t;

  int unsigned grid_width = 64, grid_height = 64, link_radius_sq = 1;
  logic [31:0] near_threshold_sq = 32'd65536;

  int unsigned pt_col[1024];
  int unsigned pt_row[1024];
  bit          taken[1024];
  int unsigned point_count, cell_column, cell_row;
  bit          overflow_flag;
  frame_result_t pending[$];
  int unsigned errors, frames_checked, points_seen;

  function void set_reg(int unsigned idx, logic [31:0] val);
    case (idx)
      gocn_pkg::REG_GRID_WIDTH:  grid_width = val[6:0];
      gocn_pkg::REG_GRID_HEIGHT: grid_height = val[6:0];
      gocn_pkg::REG_LINK_RADIUS: link_radius_sq = val[13:0];
      gocn_pkg::REG_NEAR_THRESH: near_threshold_sq = val;
      default: ;
    endcase
  endfunction

  function int unsigned clamp_side(int unsigned v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function longint unsigned centre_of(longint unsigned sum, longint unsigned n);
    longint unsigned c;
    c = ((((2 * sum + n) << 8)) + n) / (2 * n);
    return (c > 16383) ? 16383 : c;
  endfunction

  function bit links(int unsigned a, int unsigned b);
    longint dc, dr;
    dc = longint'(pt_col[a]) - longint'(pt_col[b]);
    dr = longint'(pt_row[a]) - longint'(pt_row[b]);
    return (dc * dc + dr * dr) <= longint'(link_radius_sq);
  endfunction

  // Notes one accepted cell and, on the last cell, predicts the frame result.
  function void note_cell(logic signed [7:0] val, logic last, logic signed [15:0] rx,
                          logic signed [15:0] ry);
    int unsigned w, h, members, clusters;
    int unsigned members_of[1024];
    longint unsigned sx, sy, d, cx, cy;
    longint dx, dy;
    frame_result_t r;
    w = clamp_side(grid_width);
    h = clamp_side(grid_height);
    if (val == gocn_pkg::OCCUPIED) begin
      if (point_count < 1024) begin
        pt_col[point_count] = cell_column;
        pt_row[point_count] = cell_row;
        taken[point_count] = 0;
        point_count++;
        points_seen++;
      end else begin
        overflow_flag = 1;
      end
    end
    if (cell_column + 1 >= w) begin
      cell_column = 0;
      cell_row = (cell_row + 1 >= h) ? 0 : cell_row + 1;
    end else begin
      cell_column++;
    end
    if (!last) return;
    r = '0;
    clusters = 0;
    for (int i = 0; i < point_count; i++) begin
      if (taken[i]) continue;
      members_of[0] = i;
      members = 1;
      taken[i] = 1;
      for (int j = 0; j < point_count; j++) begin
        if (taken[j]) continue;
        for (int k = 0; k < members; k++) begin
          if (links(j, members_of[k])) begin
            members_of[members++] = j;
            taken[j] = 1;
            break;
          end
        end
      end
      sx = 0;
      sy = 0;
      for (int k = 0; k < members; k++) begin
        sx += pt_col[members_of[k]];
        sy += pt_row[members_of[k]];
      end
      cx = centre_of(sx, members);
      cy = centre_of(sy, members);
      dx = longint'(cx) - longint'(rx);
      dy = longint'(cy) - longint'(ry);
      d = dx * dx + dy * dy;
      if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
      if (!r.found || d[31:0] < r.distance_sq) begin
        r.distance_sq = d[31:0];
        r.centroid_x = cx[13:0];
        r.centroid_y = cy[13:0];
      end
      r.found = 1;
      clusters++;
    end
    r.cluster_count = (clusters > 2047) ? 11'd2047 : clusters[10:0];
    r.far_enough = r.found && (r.distance_sq >= near_threshold_sq);
    r.point_overflow = overflow_flag;
    pending = {pending, r};
    point_count = 0;
    cell_column = 0;
    cell_row = 0;
    overflow_flag = 0;
    foreach (taken[i]) taken[i] = 0;
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t exp;
    if (pending.size() == 0) begin
      $error("unexpected result transaction");
      errors++;
      return;
    end
    exp = pending.pop_front();
    frames_checked++;
    if (got.found !== exp.found) begin
      $error("found: expected %0d, got %0d", exp.found, got.found); errors++;
    end
    if (got.cluster_count !== exp.cluster_count) begin
      $error("cluster_count: expected %0d, got %0d", exp.cluster_count, got.cluster_count);
      errors++;
    end
    if (got.centroid_x !== exp.centroid_x) begin
      $error("centroid_x: expected %0d, got %0d", exp.centroid_x, got.centroid_x); errors++;
    end
    if (got.centroid_y !== exp.centroid_y) begin
      $error("centroid_y: expected %0d, got %0d", exp.centroid_y, got.centroid_y); errors++;
    end
    if (got.distance_sq !== exp.distance_sq) begin
      $error("distance_sq: expected %0d, got %0d", exp.distance_sq, got.distance_sq);
      errors++;
    end
    if (got.far_enough !== exp.far_enough) begin
      $error("far_enough: expected %0d, got %0d", exp.far_enough, got.far_enough); errors++;
    end
    if (got.point_overflow !== exp.point_overflow) begin
      $error("point_overflow: expected %0d, got %0d", exp.point_overflow,
             got.point_overflow);
      errors++;
    end
  endfunction
endclass

// File: tb/grid_obstacle_cluster_nearest_tb.sv
module grid_obstacle_cluster_nearest_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gocn_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  gocn_in_if  in_ch ();
  gocn_out_if out_ch ();
  gocn_cfg_if cfg_ch ();

  grid_obstacle_cluster_nearest dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  gocn_scoreboard frames = new();

  // Stall control: a percentage of idle cycles on each side, plus a long hold-off.
  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 14;
  bit          hold_receiver = 0;
  int unsigned frames_sent = 0;
  int unsigned cells_sent = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.cell_value = 0;
    in_ch.last_cell = 0;
    in_ch.robot_x = 0;
    in_ch.robot_y = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.addr = REG_GRID_WIDTH;
    cfg_ch.data = 0;
  end

  // The receiver samples each result transaction at the edge where it is accepted and
  // re-decides ready for the next cycle; the long hold-off is driven separately.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        frames.check_result('{out_ch.found, out_ch.cluster_count, out_ch.centroid_x,
                              out_ch.centroid_y, out_ch.distance_sq, out_ch.far_enough,
                              out_ch.point_overflow});
      out_ch.ready <= !hold_receiver && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    frames.set_reg(idx, val);
  endtask

  // Sends one cell; the prediction is updated at the edge where it is accepted.
  task automatic send_cell(logic signed [7:0] val, logic last, logic signed [15:0] rx,
                           logic signed [15:0] ry);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cell_value <= val;
    in_ch.last_cell <= last;
    in_ch.robot_x <= rx;
    in_ch.robot_y <= ry;
    do @(posedge clk); while (!in_ch.ready);
    frames.note_cell(val, last, rx, ry);
    cells_sent++;
    if (last) frames_sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  // Waits until every predicted result has arrived, then lets the clustering settle.
  task automatic drain();
    go_idle();
    while (frames.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [7:0] random_cell(int unsigned occ_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < occ_pct) return OCCUPIED;
    case ($urandom_range(5))
      0: return -8'sd1;
      1: return 8'sd0;
      2: return 8'sd99;
      3: return 8'sd101;
      4: return 8'sd127;
      default: return $signed(8'($urandom));
    endcase
  endfunction

  // One frame: n cells with the robot given on the final one.
  task automatic send_frame(int unsigned n, int unsigned occ_pct, logic signed [15:0] rx,
                            logic signed [15:0] ry);
    for (int unsigned i = 0; i < n; i++)
      send_cell(random_cell(occ_pct), i == n - 1, rx, ry);
  endtask

  initial begin
    automatic int unsigned w, h;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed frames on a 4 by 3 grid at the reset radius and threshold: a frame of one
    // empty cell, lone occupied cells with the robot at the extremes and close by, and a short frame.
    write_reg(REG_GRID_WIDTH, 4);
    write_reg(REG_GRID_HEIGHT, 3);
    send_cell(-8'sd1, 1'b1, 16'sh7FFF, 16'sh8000);
    send_cell(OCCUPIED, 1'b1, 16'sh8000, 16'sh7FFF);
    send_cell(OCCUPIED, 1'b1, 16'sh0080, 16'sh0080);
    send_cell(-8'sd128, 1'b0, 16'sh0000, 16'sh0000);
    send_cell(OCCUPIED, 1'b0, 16'sh0000, 16'sh0000);
    send_cell(OCCUPIED, 1'b0, 16'sh0000, 16'sh0000);
    send_cell(8'sd127, 1'b0, 16'sh0000, 16'sh0000);
    send_cell(OCCUPIED, 1'b1, 16'sh0300, 16'sh0000);
    drain();

    // Grid sizes of zero act as one, and sizes above the largest side clamp.
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_GRID_HEIGHT, 127);
    write_reg(REG_LINK_RADIUS, 0);
    write_reg(REG_NEAR_THRESH, 0);
    send_frame(6, 60, 16'sh0100, 16'sh0200);
    drain();
    write_reg(REG_GRID_WIDTH, 127);
    write_reg(REG_GRID_HEIGHT, 0);
    write_reg(REG_LINK_RADIUS, 8192);
    write_reg(REG_NEAR_THRESH, 32'hFFFF_FFFF);
    send_frame(70, 50, 16'sh8000, 16'sh8000);
    drain();

    // Too many points: a full grid of occupied cells wraps past the last row and
    // overflows the point store; a wide radius keeps it to one cluster.
    write_reg(REG_GRID_WIDTH, 64);
    write_reg(REG_GRID_HEIGHT, 16);
    for (int i = 0; i < 1030; i++) send_cell(OCCUPIED, i == 1029, 16'sh1000, 16'sh0800);
    drain();
    write_reg(REG_LINK_RADIUS, 1);
    write_reg(REG_NEAR_THRESH, 65536);

    // Random frames on small grids. Midway the receiver holds off while the sender
    // keeps offering frames, then the sender pauses until all results are in.
    while (cells_sent < 2000) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
      write_reg(REG_LINK_RADIUS, $urandom_range(0, 3) == 0 ? $urandom_range(8192) :
                                 $urandom_range(5));
      write_reg(REG_NEAR_THRESH, $urandom_range(1) ? $urandom : $urandom_range(200000));
      send_idle_pct = (frames_sent % 10 == 5) ? 0 : 14;
      recv_idle_pct = (frames_sent % 10 == 5) ? 0 : 14;
      for (int f = 0; f < 4; f++)
        send_frame($urandom_range(1, w * h + 3), $urandom_range(10, 70),
                   16'($urandom_range(1) ? $urandom : $urandom_range(3000)),
                   16'($urandom_range(1) ? $urandom : $urandom_range(3000)));
      if (frames_sent >= 40 && frames_sent < 44) begin
        fork
          begin
            hold_receiver = 1;
            repeat (3000) @(posedge clk);
            hold_receiver = 0;
          end
          for (int f = 0; f < 4; f++) send_frame(w * h, 40, 16'sh0200, 16'sh0200);
        join
      end
      drain();
    end

    $display("Covered %0d cells, %0d frames and %0d points; %0d results checked.",
             cells_sent, frames_sent, frames.points_seen, frames.frames_checked);
    if (frames.errors == 0 && frames.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// File: sim.f
src/gocn_pkg.sv
src/gocn_ifs.sv
src/gocn_ram.sv
src/grid_obstacle_cluster_nearest.sv
tb/gocn_scoreboard.sv
tb/grid_obstacle_cluster_nearest_tb.sv
